>>> rtl/cdcs_pkg.sv
// Shared constants and types for the causal depthwise convolution with SiLU.
package cdcs_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int CHANNEL_W    = 12;
   localparam int HIST_SLOTS   = 3;
   localparam int HIST_W       = SAMPLE_W * HIST_SLOTS;
   localparam int CHANNELS_DEF = 4096;
   localparam int TAPS_DEF     = 4;
   localparam int TAY_TERMS    = 12;
   localparam int DIV_W        = 64;
   localparam int DVS_W        = 34;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef struct packed {
      logic clr_wr;
      logic load;
      logic mac_step;
      logic hist_wr;
      logic kdiv_go;
      logic kdiv_take;
      logic tmul;
      logic tdiv_go;
      logic tdiv_take;
      logic exp_calc;
      logic sdiv_go;
      logic sdiv_take;
      logic fmul;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mac_last;
      logic kdiv_done;
      logic div_done;
      logic tay_last;
   } sts_type;

endpackage

>>> rtl/cdcs_if.sv
// Request and response channel interfaces.
interface cdcs_req_if;
   logic               valid;
   logic               ready;
   logic [11:0]        channel;
   logic signed [15:0] sample;
   logic signed [15:0] tap_weight_0;
   logic signed [15:0] tap_weight_1;
   logic signed [15:0] tap_weight_2;
   logic signed [15:0] tap_weight_3;
   modport source (output valid, channel, sample, tap_weight_0, tap_weight_1,
                   tap_weight_2, tap_weight_3, input ready);
   modport sink (input valid, channel, sample, tap_weight_0, tap_weight_1,
                 tap_weight_2, tap_weight_3, output ready);
endinterface

interface cdcs_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        channel_out;
   logic signed [15:0] activated;
   modport source (output valid, channel_out, activated, input ready);
   modport sink (input valid, channel_out, activated, output ready);
endinterface

>>> rtl/causal_depthwise_conv_silu_top.sv
// Sequence from the accepting edge to rsp valid: the MAC steps over the taps, a history
// write, an exponent split (six compare-and-subtract steps), twelve series
// terms on the shared bit-serial divider, then the sigmoid division.
// Throughput: one beat in flight; a new beat is taken only after the result is sent.
// Reset: synchronous; a clear sweep then zeroes every entry of the history
// memory before the first beat is taken.
module causal_depthwise_conv_silu_top #(
   parameter int CHANNELS    = cdcs_pkg::CHANNELS_DEF,
   parameter int KERNEL_TAPS = cdcs_pkg::TAPS_DEF
) (
   input logic clock,
   input logic reset,
   cdcs_req_if.sink   req_ch,
   cdcs_rsp_if.source rsp_ch
);
   import cdcs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cdcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdcs_dp #(.CHANNELS(CHANNELS), .KERNEL_TAPS(KERNEL_TAPS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .in_channel    (req_ch.channel),
      .in_sample     (req_ch.sample),
      .in_w0         (req_ch.tap_weight_0),
      .in_w1         (req_ch.tap_weight_1),
      .in_w2         (req_ch.tap_weight_2),
      .in_w3         (req_ch.tap_weight_3),
      .out_channel   (rsp_ch.channel_out),
      .out_activated (rsp_ch.activated)
   );

   // one beat in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a result is pending");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready && !rsp_ch.valid)
      else $error("controller did not start work after a beat");

   a_drop_after_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> !rsp_ch.valid)
      else $error("result repeated");
endmodule

>>> rtl/cdcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdcs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/cdcs_div.sv
// Restoring divider, one quotient bit per cycle.
module cdcs_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [cdcs_pkg::DIV_W-1:0] dividend,
   input  logic [cdcs_pkg::DVS_W-1:0] divisor,
   output logic done,
   output logic [cdcs_pkg::DIV_W-1:0] quotient
);
   import cdcs_pkg::*;

   logic [DIV_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff, dvs_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff, done_ff;
   logic [DVS_W:0]   rem_w;
   logic             ge;

   assign rem_w = {rem_ff, quo_ff[DIV_W-1]};
   assign ge    = rem_w >= {1'b0, dvs_ff};

   // control: count iterations, pulse done at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: shift and conditionally subtract
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= ge ? DVS_W'(rem_w - {1'b0, dvs_ff}) : rem_w[DVS_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> rtl/cdcs_dp.sv
// Datapath: history memory, MAC, exp series, sigmoid division and output.
module cdcs_dp #(
   parameter int CHANNELS    = cdcs_pkg::CHANNELS_DEF,
   parameter int KERNEL_TAPS = cdcs_pkg::TAPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  cdcs_pkg::cmd_type cmd,
   output cdcs_pkg::sts_type sts,
   input  logic [11:0]        in_channel,
   input  logic signed [15:0] in_sample,
   input  logic signed [15:0] in_w0,
   input  logic signed [15:0] in_w1,
   input  logic signed [15:0] in_w2,
   input  logic signed [15:0] in_w3,
   output logic [11:0]        out_channel,
   output logic signed [15:0] out_activated
);
   import cdcs_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [40:0] KBIG_Y = 41'(LN2_Q32) * 41'd33;

   logic [11:0]        ch_ff;
   logic               chv_ff;
   logic signed [15:0] x_ff;
   logic signed [15:0] w_ff [4];
   logic [AW-1:0]      clr_ff, ch_addr, item_addr;
   logic [AW+11:0]     ch_ext, item_ext;
   logic               in_chv;
   logic               ram_wr;
   logic [AW-1:0]      ram_waddr;
   logic [HIST_W-1:0]  ram_wdata, ram_rdata;
   logic signed [15:0] h [HIST_SLOTS];
   logic [1:0]         mac_ff;
   logic signed [15:0] mac_a, mac_b;
   logic signed [31:0] mac_prod;
   logic               tap_on;
   logic signed [34:0] acc_ff;
   logic [32:0]        mag_ff;
   logic               neg_ff;
   logic               kbig_ff;
   logic [5:0]         k_ff;
   logic [40:0]        ky_ff, kstep_val;
   logic [5:0]         kq_ff;
   logic [2:0]         kcnt_ff;
   logic               kbusy_ff, kdone_ff, kge;
   logic [31:0]        r_ff;
   logic [32:0]        term_ff;
   logic signed [34:0] sum_ff;
   logic [3:0]         n_ff;
   logic [31:0]        tprod_ff;
   logic [64:0]        tprod_w;
   logic [32:0]        e_ff;
   logic [33:0]        sum_pos;
   logic [30:0]        sig_ff;
   logic [63:0]        fprod_ff;
   logic [64:0]        fround;
   logic [22:0]        q;
   logic [11:0]        och_ff;
   logic signed [15:0] oact_ff;
   logic               div_go, div_done;
   logic [DIV_W-1:0]   div_dvd, div_quo;
   logic [DVS_W-1:0]   div_dvs;

   // map the 12-bit channel onto the memory address
   assign ch_ext    = {{AW{1'b0}}, in_channel};
   assign ch_addr   = ch_ext[AW-1:0];
   assign item_ext  = {{AW{1'b0}}, ch_ff};
   assign item_addr = item_ext[AW-1:0];
   assign in_chv    = 32'(in_channel) < 32'(CHANNELS);

   // clear sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign ram_wr    = cmd.clr_wr | (cmd.hist_wr & chv_ff);
   assign ram_waddr = cmd.clr_wr ? clr_ff : item_addr;
   assign ram_wdata = cmd.clr_wr ? '0 : {x_ff, h[2], h[1]};

   cdcs_ram #(.WIDTH(HIST_W), .DEPTH(CHANNELS)) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.load),
      .rd_addr (ch_addr),
      .rd_data (ram_rdata)
   );

   // history slots, oldest first; out-of-range channels read as zero
   always_comb begin
      for (int i = 0; i < HIST_SLOTS; i++) begin
         h[i] = chv_ff ? $signed(ram_rdata[i*SAMPLE_W +: SAMPLE_W]) : 16'sd0;
      end
   end

   // latch the item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff   <= in_channel;
         chv_ff  <= in_chv;
         x_ff    <= in_sample;
         w_ff[0] <= in_w0;
         w_ff[1] <= in_w1;
         w_ff[2] <= in_w2;
         w_ff[3] <= in_w3;
      end
   end

   // MAC operand select, one tap a cycle
   always_comb begin
      case (mac_ff)
         2'd0: begin mac_a = w_ff[0]; mac_b = h[0]; end
         2'd1: begin mac_a = w_ff[1]; mac_b = h[1]; end
         2'd2: begin mac_a = w_ff[2]; mac_b = h[2]; end
         default: begin mac_a = w_ff[3]; mac_b = x_ff; end
      endcase
   end
   assign mac_prod = mac_a * mac_b;
   assign tap_on   = (32'(mac_ff) + 32'(KERNEL_TAPS)) >= 32'd4;

   // accumulate and take the magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= '0;
      end else if (cmd.load) begin
         mac_ff <= '0;
      end else if (cmd.mac_step) begin
         mac_ff <= mac_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.mac_step && tap_on) begin
         acc_ff <= acc_ff + 35'(mac_prod);
      end
      if (cmd.hist_wr) begin
         neg_ff <= acc_ff[34];
         mag_ff <= acc_ff[34] ? 33'(-acc_ff) : 33'(acc_ff);
      end
   end

   // split y into k * ln2 + r: six compare-and-subtract steps, k below 64
   assign kstep_val = 41'(LN2_Q32) << kcnt_ff;
   assign kge       = ky_ff >= kstep_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         kbusy_ff <= 1'b0;
         kdone_ff <= 1'b0;
      end else begin
         kdone_ff <= 1'b0;
         if (cmd.kdiv_go) begin
            kbusy_ff <= 1'b1;
         end else if (kbusy_ff && kcnt_ff == 3'd0) begin
            kbusy_ff <= 1'b0;
            kdone_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kdiv_go) begin
         ky_ff   <= {mag_ff, 8'd0};
         kq_ff   <= '0;
         kcnt_ff <= 3'd5;
      end else if (kbusy_ff) begin
         if (kge) begin
            ky_ff <= ky_ff - kstep_val;
         end
         kq_ff   <= {kq_ff[4:0], kge};
         kcnt_ff <= kcnt_ff - 3'd1;
      end
   end

   // divider operand select
   always_comb begin
      div_go  = cmd.tdiv_go | cmd.sdiv_go;
      div_dvd = {32'd0, tprod_ff};
      div_dvs = DVS_W'(n_ff);
      if (cmd.sdiv_go) begin
         div_dvd = neg_ff ? {1'b0, e_ff, 30'd0} : {2'b01, 62'd0};
         div_dvs = DVS_W'(35'h1_0000_0000 + 35'(e_ff));
      end
   end

   cdcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo)
   );

   assign tprod_w = 65'(term_ff) * 65'(r_ff);
   assign sum_pos = sum_ff[34] ? '0 : sum_ff[33:0];
   assign fround  = 65'(fprod_ff) + (65'd1 << 41);
   assign q       = fround[64:42];

   // series, exponent, sigmoid and final scaling
   always_ff @(posedge clock) begin
      if (cmd.kdiv_take) begin
         kbig_ff <= {mag_ff, 8'd0} >= KBIG_Y;
         k_ff    <= kq_ff;
         r_ff    <= ky_ff[31:0];
         term_ff <= 33'h1_0000_0000;
         sum_ff  <= 35'sh1_0000_0000;
         n_ff    <= 4'd1;
      end
      if (cmd.tmul) begin
         tprod_ff <= tprod_w[63:32];
      end
      if (cmd.tdiv_take) begin
         term_ff <= div_quo[32:0];
         sum_ff  <= n_ff[0] ? sum_ff - $signed({2'b00, div_quo[32:0]})
                            : sum_ff + $signed({2'b00, div_quo[32:0]});
         n_ff    <= n_ff + 4'd1;
      end
      if (cmd.exp_calc) begin
         e_ff <= kbig_ff ? '0 : 33'(sum_pos >> k_ff);
      end
      if (cmd.sdiv_take) begin
         sig_ff <= div_quo[30:0];
      end
      if (cmd.fmul) begin
         fprod_ff <= mag_ff * sig_ff;
      end
      if (cmd.fin) begin
         och_ff <= ch_ff;
         if (neg_ff) begin
            oact_ff <= (q > 23'd32768) ? -16'sd32768 : 16'(-q);
         end else begin
            oact_ff <= (q > 23'd32767) ? 16'sd32767 : 16'(q);
         end
      end
   end

   assign sts.clr_last  = clr_ff == AW'(CHANNELS - 1);
   assign sts.mac_last  = mac_ff == 2'd3;
   assign sts.kdiv_done = kdone_ff;
   assign sts.div_done  = div_done;
   assign sts.tay_last  = n_ff == 4'(TAY_TERMS);

   assign out_channel   = och_ff;
   assign out_activated = oact_ff;
endmodule

>>> rtl/cdcs_ctrl.sv
// Controller: sequences clear sweep, MAC, exp series, division and output.
module cdcs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  cdcs_pkg::sts_type sts,
   output cdcs_pkg::cmd_type cmd
);
   import cdcs_pkg::*;

   typedef enum logic [15:0] {
      S_CLEAR = 16'h0001,
      S_IDLE  = 16'h0002,
      S_MAC   = 16'h0004,
      S_HWR   = 16'h0008,
      S_KDIV  = 16'h0010,
      S_KWAIT = 16'h0020,
      S_TMUL  = 16'h0040,
      S_TDIV  = 16'h0080,
      S_TWAIT = 16'h0100,
      S_EXP   = 16'h0200,
      S_SDIV  = 16'h0400,
      S_SWAIT = 16'h0800,
      S_FMUL  = 16'h1000,
      S_FIN   = 16'h2000,
      S_OUT   = 16'h4000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.mac_step = 1'b1;
            if (sts.mac_last) state_in = S_HWR;
         end
         S_HWR: begin
            cmd.hist_wr = 1'b1;
            state_in    = S_KDIV;
         end
         S_KDIV: begin
            cmd.kdiv_go = 1'b1;
            state_in    = S_KWAIT;
         end
         S_KWAIT: begin
            if (sts.kdiv_done) begin
               cmd.kdiv_take = 1'b1;
               state_in      = S_TMUL;
            end
         end
         S_TMUL: begin
            cmd.tmul = 1'b1;
            state_in = S_TDIV;
         end
         S_TDIV: begin
            cmd.tdiv_go = 1'b1;
            state_in    = S_TWAIT;
         end
         S_TWAIT: begin
            if (sts.div_done) begin
               cmd.tdiv_take = 1'b1;
               state_in      = sts.tay_last ? S_EXP : S_TMUL;
            end
         end
         S_EXP: begin
            cmd.exp_calc = 1'b1;
            state_in     = S_SDIV;
         end
         S_SDIV: begin
            cmd.sdiv_go = 1'b1;
            state_in    = S_SWAIT;
         end
         S_SWAIT: begin
            if (sts.div_done) begin
               cmd.sdiv_take = 1'b1;
               state_in      = S_FMUL;
            end
         end
         S_FMUL: begin
            cmd.fmul = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
